// ===== src/fraction_arithmetic_reduce_top_assert.svh =====
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce_top_assert
// Assertion macros for the fraction reduce block.
// ----------------------------------------------------------------------------
`ifndef FRACTION_ARITHMETIC_REDUCE_TOP_ASSERT_SVH
`define FRACTION_ARITHMETIC_REDUCE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FAR_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FAR_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define FAR_ASSERT_IMPL(label, clk, rst, prop, msg)
`define FAR_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== src/far_pkg.sv =====
// ----------------------------------------------------------------------------
// far_pkg
// Shared widths, operation codes and the queue word type.
// ----------------------------------------------------------------------------
package far_pkg;
   localparam int OperandWidth = 16;
   localparam int ResultWidth  = 2 * OperandWidth + 1;
   localparam int QueueDepth   = 2;
   localparam int QueuePtrWidth = 1;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef struct packed {
      logic signed [ResultWidth-1:0] num;
      logic signed [ResultWidth-1:0] den;
   } frac_type;
endpackage

// ===== src/fraction_arithmetic_reduce_top.sv =====
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce_top
// Fraction add/sub/mul/div with GCD reduction of the result.
// ----------------------------------------------------------------------------
// The front stage takes an item, registers the products and then the combined
// fraction; a two-entry queue feeds the back stage, which runs a binary GCD (up
// to about 2*33 steps) and two 33-step restoring divisions on the shared
// divider, and takes no new item until its result is taken.
// Results with a zero part skip reduction.
module fraction_arithmetic_reduce_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_cmd,
   input  logic signed [far_pkg::OperandWidth-1:0] req_numerator_a,
   input  logic signed [far_pkg::OperandWidth-1:0] req_denominator_a,
   input  logic signed [far_pkg::OperandWidth-1:0] req_numerator_b,
   input  logic signed [far_pkg::OperandWidth-1:0] req_denominator_b,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [far_pkg::ResultWidth-1:0] rsp_result_numerator,
   output logic signed [far_pkg::ResultWidth-1:0] rsp_result_denominator
);
   logic f_valid, f_stall, b_valid, b_stall;
   far_pkg::frac_type f_word, b_word;

   far_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .req_numerator_a,
      .req_denominator_a, .req_numerator_b, .req_denominator_b,
      .q_valid(f_valid), .q_stall(f_stall), .q_word(f_word)
   );

   far_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_stall(f_stall), .wr_word(f_word),
      .rd_valid(b_valid), .rd_stall(b_stall), .rd_word(b_word)
   );

   far_back u_back (
      .clock, .reset, .q_valid(b_valid), .q_stall(b_stall), .q_word(b_word),
      .rsp_valid, .rsp_stall, .rsp_result_numerator, .rsp_result_denominator
   );
endmodule

// ===== src/far_front.sv =====
// ----------------------------------------------------------------------------
// far_front
// Accepts an item, forms the unreduced fraction in a multiply stage and a combine stage.
// ----------------------------------------------------------------------------
module far_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_cmd,
   input  logic signed [far_pkg::OperandWidth-1:0] req_numerator_a,
   input  logic signed [far_pkg::OperandWidth-1:0] req_denominator_a,
   input  logic signed [far_pkg::OperandWidth-1:0] req_numerator_b,
   input  logic signed [far_pkg::OperandWidth-1:0] req_denominator_b,
   output logic q_valid,
   input  logic q_stall,
   output far_pkg::frac_type q_word
);
   localparam int W = far_pkg::OperandWidth;
   localparam int R = far_pkg::ResultWidth;
   localparam int P = 2 * W;

   logic s1_ff, s1_in, s2_ff, s2_in;
   logic [1:0] cmd_ff;
   logic same_ff;
   logic signed [W-1:0] na_ff, da_ff, nb_ff;
   logic signed [P-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [R-1:0] na_x, nb_x, da_x;
   far_pkg::frac_type word_ff, word_in;

   assign s2_in = (s1_ff && !(s2_ff && q_stall)) || (s2_ff && q_stall);
   assign req_stall = s1_ff && s2_ff && q_stall;
   assign s1_in = (req_valid && !req_stall) || (s1_ff && req_stall);
   assign q_valid = s2_ff;
   assign q_word = word_ff;

   assign na_x = R'(na_ff);
   assign nb_x = R'(nb_ff);
   assign da_x = R'(da_ff);

   always_comb begin
      word_in.num = '0;
      word_in.den = '0;
      case (far_pkg::cmd_type'(cmd_ff))
         far_pkg::CMD_ADD: begin
            if (same_ff) begin
               word_in.num = na_x + nb_x;
               word_in.den = da_x;
            end else begin
               word_in.num = R'(p0_ff) + R'(p1_ff);
               word_in.den = R'(p2_ff);
            end
         end
         far_pkg::CMD_SUB: begin
            if (same_ff) begin
               word_in.num = na_x - nb_x;
               word_in.den = da_x;
            end else begin
               word_in.num = R'(p0_ff) - R'(p1_ff);
               word_in.den = R'(p2_ff);
            end
         end
         default: begin
            word_in.num = R'(p0_ff);
            word_in.den = R'(p2_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
      if (req_valid && !req_stall) begin
         cmd_ff <= req_cmd;
         same_ff <= (req_denominator_a == req_denominator_b);
         na_ff <= req_numerator_a;
         da_ff <= req_denominator_a;
         nb_ff <= req_numerator_b;
         case (far_pkg::cmd_type'(req_cmd))
            far_pkg::CMD_MUL: begin
               p0_ff <= P'(req_numerator_a) * P'(req_numerator_b);
               p1_ff <= '0;
               p2_ff <= P'(req_denominator_a) * P'(req_denominator_b);
            end
            far_pkg::CMD_DIV: begin
               p0_ff <= P'(req_numerator_a) * P'(req_denominator_b);
               p1_ff <= '0;
               p2_ff <= P'(req_numerator_b) * P'(req_denominator_a);
            end
            default: begin
               p0_ff <= P'(req_numerator_a) * P'(req_denominator_b);
               p1_ff <= P'(req_numerator_b) * P'(req_denominator_a);
               p2_ff <= P'(req_denominator_a) * P'(req_denominator_b);
            end
         endcase
      end
      if (s1_ff && !req_stall) word_ff <= word_in;
   end
endmodule

// ===== src/far_queue.sv =====
// ----------------------------------------------------------------------------
// far_queue
// Two-entry queue between the front stage and reduction.
// ----------------------------------------------------------------------------
`include "fraction_arithmetic_reduce_top_assert.svh"
module far_queue (
   input  logic clock,
   input  logic reset,
   input  logic wr_valid,
   output logic wr_stall,
   input  far_pkg::frac_type wr_word,
   output logic rd_valid,
   input  logic rd_stall,
   output far_pkg::frac_type rd_word
);
   localparam int Pw = far_pkg::QueuePtrWidth;
   far_pkg::frac_type mem_ff [far_pkg::QueueDepth];
   logic [Pw-1:0] wp_ff, rp_ff;
   logic [Pw:0] cnt_ff;
   logic push, pop;

   assign wr_stall = (cnt_ff == (Pw+1)'(far_pkg::QueueDepth));
   assign rd_valid = (cnt_ff != '0);
   assign push = wr_valid && !wr_stall;
   assign pop = rd_valid && !rd_stall;
   assign rd_word = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (Pw+1)'(push) - (Pw+1)'(pop);
      end
      if (push) mem_ff[wp_ff] <= wr_word;
   end

   `FAR_ASSERT_IMPL(a_cnt_range, clock, reset, cnt_ff <= (Pw+1)'(far_pkg::QueueDepth), "queue overflow")
   `FAR_ASSERT_NEXT(a_full_hold, clock, reset, wr_stall && !pop, wr_stall, "full dropped without pop")
   `FAR_ASSERT_NEXT(a_push_valid, clock, reset, push && !pop, rd_valid, "pushed word lost")
endmodule

// ===== src/far_back.sv =====
// ----------------------------------------------------------------------------
// far_back
// Binary GCD of the magnitudes, then two restoring divisions by it; results with a zero part pass unreduced.
// ----------------------------------------------------------------------------
`include "fraction_arithmetic_reduce_top_assert.svh"
module far_back (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_stall,
   input  far_pkg::frac_type q_word,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [far_pkg::ResultWidth-1:0] rsp_result_numerator,
   output logic signed [far_pkg::ResultWidth-1:0] rsp_result_denominator
);
   localparam int R = far_pkg::ResultWidth;
   localparam int Cw = $clog2(R + 1) + 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_GCD  = 5'b00010,
      ST_DIVN = 5'b00100,
      ST_DIVD = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type st_ff, st_in;
   logic sn_ff, sd_ff;
   logic [R-1:0] mn_ff, md_ff, x_ff, y_ff, g_ff, qn_ff, qd_ff, quo_ff, rem_ff, dv_ff;
   logic [Cw-1:0] sh_ff, cnt_ff;
   logic signed [R-1:0] on_ff, od_ff;
   logic [R:0] trial;
   logic [R-1:0] an, ad;

   assign q_stall = (st_ff != ST_IDLE);
   assign rsp_valid = (st_ff == ST_OUT);
   assign rsp_result_numerator = on_ff;
   assign rsp_result_denominator = od_ff;
   assign an = q_word.num[R-1] ? R'(-q_word.num) : R'(q_word.num);
   assign ad = q_word.den[R-1] ? R'(-q_word.den) : R'(q_word.den);
   assign trial = {rem_ff, quo_ff[R-1]} - {1'b0, dv_ff};

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (q_valid) st_in = (an != '0 && ad != '0) ? ST_GCD : ST_OUT;
         ST_GCD: if (x_ff == y_ff) st_in = ST_DIVN;
         ST_DIVN: if (cnt_ff == Cw'(R - 1)) st_in = ST_DIVD;
         ST_DIVD: if (cnt_ff == Cw'(R - 1)) st_in = ST_OUT;
         ST_OUT: if (!rsp_stall) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
      case (st_ff)
         ST_IDLE: begin
            sn_ff <= q_word.num[R-1];
            sd_ff <= q_word.den[R-1];
            mn_ff <= an;
            md_ff <= ad;
            x_ff <= an;
            y_ff <= ad;
            sh_ff <= '0;
            on_ff <= q_word.num;
            od_ff <= q_word.den;
         end
         ST_GCD: begin
            if (x_ff == y_ff) begin
               g_ff <= x_ff << sh_ff;
               dv_ff <= x_ff << sh_ff;
               quo_ff <= mn_ff;
               rem_ff <= '0;
               cnt_ff <= '0;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_ff <= x_ff >> 1;
               y_ff <= y_ff >> 1;
               sh_ff <= sh_ff + 1'b1;
            end else if (!x_ff[0]) x_ff <= x_ff >> 1;
            else if (!y_ff[0]) y_ff <= y_ff >> 1;
            else if (x_ff > y_ff) x_ff <= (x_ff - y_ff) >> 1;
            else y_ff <= (y_ff - x_ff) >> 1;
         end
         ST_DIVN, ST_DIVD: begin
            if (!trial[R]) begin
               rem_ff <= trial[R-1:0];
               quo_ff <= {quo_ff[R-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[R-2:0], quo_ff[R-1]};
               quo_ff <= {quo_ff[R-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == Cw'(R - 1)) begin
               cnt_ff <= '0;
               rem_ff <= '0;
               if (st_ff == ST_DIVN) begin
                  qn_ff <= {quo_ff[R-2:0], ~trial[R]};
                  quo_ff <= md_ff;
               end else begin
                  qd_ff <= {quo_ff[R-2:0], ~trial[R]};
               end
            end
         end
         default: ;
      endcase
      if (st_ff == ST_DIVD && cnt_ff == Cw'(R - 1)) begin
         on_ff <= sn_ff ? -$signed(qn_ff) : $signed(qn_ff);
         od_ff <= sd_ff ? -$signed({quo_ff[R-2:0], ~trial[R]})
                        : $signed({quo_ff[R-2:0], ~trial[R]});
      end
   end

   `FAR_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_numerator), "result changed while stalled")
   `FAR_ASSERT_IMPL(a_onehot, clock, reset, $onehot(st_ff), "state not one-hot")
   `FAR_ASSERT_IMPL(a_gcd_nz, clock, reset, !(st_ff == ST_DIVN) || g_ff != '0, "zero divisor")
endmodule

// ===== dv/fraction_arithmetic_reduce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce_checker
// Watches the request and response channels of the fraction reduce block,
// computes the reduced fraction for every accepted request word and compares
// each accepted response word against the oldest pending fraction.
// ----------------------------------------------------------------------------
module fraction_arithmetic_reduce_checker
   import far_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic [1:0] req_cmd,
   input  logic signed [OperandWidth-1:0] req_numerator_a,
   input  logic signed [OperandWidth-1:0] req_denominator_a,
   input  logic signed [OperandWidth-1:0] req_numerator_b,
   input  logic signed [OperandWidth-1:0] req_denominator_b,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic signed [ResultWidth-1:0] rsp_result_numerator,
   input  logic signed [ResultWidth-1:0] rsp_result_denominator,
   output int   error_count,
   output int   pending_count
);
   frac_type pending_fracs[$];

   function automatic longint unsigned magnitude_of(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic frac_type reduce_fraction(cmd_type cmd, longint na, longint da,
                                                longint nb, longint db);
      longint num;
      longint den;
      longint unsigned x;
      longint unsigned y;
      longint unsigned t;
      frac_type f;
      case (cmd)
         CMD_ADD, CMD_SUB: begin
            if (da == db) begin
               den = da;
               num = (cmd == CMD_ADD) ? na + nb : na - nb;
            end else begin
               den = da * db;
               num = (cmd == CMD_ADD) ? na * db + nb * da : na * db - nb * da;
            end
         end
         CMD_MUL: begin
            num = na * nb;
            den = da * db;
         end
         default: begin
            num = na * db;
            den = nb * da;
         end
      endcase
      if (num != 0 && den != 0) begin
         x = magnitude_of(num);
         y = magnitude_of(den);
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         if (x > 1) begin
            num = num / longint'(x);
            den = den / longint'(x);
         end
      end
      f.num = num[ResultWidth-1:0];
      f.den = den[ResultWidth-1:0];
      return f;
   endfunction

   assign pending_count = pending_fracs.size();

   always @(posedge clock) begin
      frac_type want;
      if (reset) begin
         error_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            pending_fracs.push_back(reduce_fraction(cmd_type'(req_cmd),
               longint'(req_numerator_a), longint'(req_denominator_a),
               longint'(req_numerator_b), longint'(req_denominator_b)));
         if (rsp_valid && !rsp_stall) begin
            if (pending_fracs.size() == 0) begin
               $error("unexpected response word");
               error_count <= error_count + 1;
            end else begin
               want = pending_fracs.pop_front();
               if (want.num !== rsp_result_numerator || want.den !== rsp_result_denominator)
                  error_count <= error_count + 1;
               if (want.num !== rsp_result_numerator)
                  $error("result_numerator: expected %0d, actual %0d",
                         want.num, rsp_result_numerator);
               if (want.den !== rsp_result_denominator)
                  $error("result_denominator: expected %0d, actual %0d",
                         want.den, rsp_result_denominator);
            end
         end
      end
   end
endmodule

// ===== dv/fraction_arithmetic_reduce_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce_top_tb
// Drives directed and random fraction requests through the reduce block
// under three idle patterns and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module fraction_arithmetic_reduce_top_tb;
   import far_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = '0;
   logic signed [OperandWidth-1:0] req_numerator_a = '0;
   logic signed [OperandWidth-1:0] req_denominator_a = '0;
   logic signed [OperandWidth-1:0] req_numerator_b = '0;
   logic signed [OperandWidth-1:0] req_denominator_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [ResultWidth-1:0] rsp_result_numerator;
   logic signed [ResultWidth-1:0] rsp_result_denominator;
   int error_count;
   int pending_count;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   always #1 clock = ~clock;

   fraction_arithmetic_reduce_top uut (.*);

   fraction_arithmetic_reduce_checker checker_i (.*);

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   task automatic send_word(cmd_type cmd, logic [OperandWidth-1:0] na,
                            logic [OperandWidth-1:0] da, logic [OperandWidth-1:0] nb,
                            logic [OperandWidth-1:0] db);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_numerator_a <= na;
      req_denominator_a <= da;
      req_numerator_b <= nb;
      req_denominator_b <= db;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [OperandWidth-1:0] pick_operand();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return logic'($urandom_range(1)) ? 16'hffff : 16'h0001;
         3: return '0;
         4: return OperandWidth'($urandom_range(40)) - 16'd20;
         default: return OperandWidth'($urandom);
      endcase
   endfunction

   task automatic run_random(int count);
      logic [OperandWidth-1:0] da;
      for (int i = 0; i < count; i++) begin
         da = pick_operand();
         send_word(cmd_type'($urandom_range(3)), pick_operand(), da, pick_operand(),
                   ($urandom_range(3) == 0) ? da : pick_operand());
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int c = 0; c < 4; c++) begin
         send_word(cmd_type'(c), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
         send_word(cmd_type'(c), 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
         send_word(cmd_type'(c), 16'h0000, 16'h0003, 16'h0005, 16'h0003);
         send_word(cmd_type'(c), -16'sd6, 16'h0004, 16'h0009, -16'sd10);
         send_word(cmd_type'(c), 16'h0001, 16'h0000, 16'h0001, 16'h0002);
      end
      send_word(CMD_ADD, 16'h0001, 16'h0002, 16'hffff, 16'h0002);
      send_word(CMD_DIV, 16'h0004, 16'h0006, 16'h0000, 16'h0003);
      req_valid <= 1'b0;
      send_idle_pct = 16;
      recv_idle_pct = 80;
      run_random(130);
      send_idle_pct = 80;
      recv_idle_pct = 16;
      run_random(130);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(140);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("** fraction_arithmetic_reduce_top: PASSED **");
      else
         $display("** fraction_arithmetic_reduce_top: FAILED **");
      $finish;
   end

   initial begin
      #2000000;
      $display("** fraction_arithmetic_reduce_top: FAILED **");
      $finish;
   end
endmodule
